@@ design/assert_macros.svh @@
// Assertion macros for the limit order matcher RTL, included by the back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Assert an implication every clock, disabled in reset.
`define LOM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Assert a next-cycle implication every clock, disabled in reset.
`define LOM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LOM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LOM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/lom_pkg.sv @@
// Package for the limit order matcher: types, codes and defaults.
package lom_pkg;
	localparam int DefOrderSlots = 32;
	localparam int QueueDepth = 2;

	typedef enum logic [2:0] {
		KIND_FILL        = 3'd0,
		KIND_RESTED      = 3'd1,
		KIND_FILLED      = 3'd2,
		KIND_CXL_DONE    = 3'd3,
		KIND_CXL_MISSING = 3'd4,
		KIND_DROPPED     = 3'd5
	} kind_t;

	typedef enum logic {
		OP_ADD    = 1'b0,
		OP_CANCEL = 1'b1
	} opcode_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		logic        is_cancel;
		logic        is_sell;
		logic [63:0] ident;
		logic [31:0] price;
		logic [31:0] qty;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FILL,
		ST_FINAL,
		ST_OUT
	} state_t;
endpackage

@@ design/lom_front.sv @@
// Front end: takes input transfers, classifies them and queues commands.
module lom_front
	import lom_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [129:0] in_data,
	output logic         cmd_valid,
	input  logic         cmd_ready,
	output cmd_t         cmd
);
	localparam int PtrW = $clog2(QueueDepth);
	cmd_t            fifo_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0]   cnt_q;
	cmd_t            cmd_in;
	logic            push, pop;

	// Decode the packed payload into a command.
	always_comb begin
		cmd_in.is_cancel = (in_data[0] == OP_CANCEL);
		cmd_in.is_sell   = in_data[1];
		cmd_in.ident     = in_data[65:2];
		cmd_in.price     = in_data[97:66];
		cmd_in.qty       = in_data[129:98];
	end

	assign in_ready  = (cnt_q != (PtrW+1)'(QueueDepth));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= cmd_in;
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PtrW'(QueueDepth-1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PtrW'(QueueDepth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end
endmodule

@@ design/lom_back.sv @@
// Back end: slot table, best-match scan, fills, resting and cancels.
`include "assert_macros.svh"
module lom_back
	import lom_pkg::*;
#(
	parameter int ORDER_SLOTS = DefOrderSlots
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_ready,
	input  cmd_t         cmd,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [162:0] out_data,
	output logic         out_last
);
	localparam int IdxW = $clog2(ORDER_SLOTS);
	localparam int CntW = $clog2(ORDER_SLOTS + 1);

	logic [ORDER_SLOTS-1:0] valid_q;
	logic                   sell_q [ORDER_SLOTS];
	logic [31:0]            price_q [ORDER_SLOTS];
	logic [31:0]            sqty_q [ORDER_SLOTS];
	logic [63:0]            ident_q [ORDER_SLOTS];
	logic [31:0]            arr_q [ORDER_SLOTS];
	logic [31:0]            arrival_q;

	state_t state_q, state_d;
	cmd_t   cur_q;
	logic [IdxW-1:0] scan_q;
	logic            found_q;
	logic [IdxW-1:0] best_q;
	logic [31:0]     bprice_q, bage_q;
	logic [CntW-1:0] nfill_q;
	logic            ofree_q;
	logic [IdxW-1:0] free_q;
	logic            cfound_q;
	logic [IdxW-1:0] cidx_q;

	logic [2:0]  okind_q;
	logic [63:0] omaker_q;
	logic [31:0] oqty_q, oprice_q, orem_q;
	logic        olast_q;

	// Per-slot candidate test at the scan index.
	logic        cand, better;
	logic [31:0] p_i, age_i;
	logic [31:0] traded;
	logic        scan_end;
	always_comb begin
		p_i   = price_q[scan_q];
		age_i = arrival_q - arr_q[scan_q];
		cand  = valid_q[scan_q] && (sell_q[scan_q] != cur_q.is_sell) &&
			(cur_q.is_sell ? (p_i != '0 && p_i >= cur_q.price) : (p_i <= cur_q.price));
		if (!found_q) better = 1'b1;
		else if (p_i != bprice_q) better = cur_q.is_sell ? (p_i > bprice_q) : (p_i < bprice_q);
		else better = age_i > bage_q;
		scan_end = (scan_q == IdxW'(ORDER_SLOTS-1));
		traded   = (cur_q.qty < sqty_q[best_q]) ? cur_q.qty : sqty_q[best_q];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (cmd_valid) state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_end) begin
					if (cur_q.is_cancel) state_d = ST_FINAL;
					else if (cur_q.qty != '0 && nfill_q != CntW'(ORDER_SLOTS) &&
						(found_q || (cand && better))) state_d = ST_FILL;
					else state_d = ST_FINAL;
				end
			end
			ST_FILL:  state_d = ST_OUT;
			ST_FINAL: state_d = ST_OUT;
			ST_OUT: begin
				if (out_ready) state_d = olast_q ? ST_IDLE : ST_SCAN;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		cmd_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
	end

	assign out_data = {orem_q, oprice_q, oqty_q, omaker_q, okind_q};
	assign out_last = olast_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			arrival_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FILL && traded == sqty_q[best_q]) valid_q[best_q] <= 1'b0;
			if (state_q == ST_FINAL) begin
				if (cur_q.is_cancel) begin
					if (cfound_q) valid_q[cidx_q] <= 1'b0;
				end else if (cur_q.qty != '0 && ofree_q) begin
					valid_q[free_q] <= 1'b1;
					arrival_q       <= arrival_q + 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cur_q   <= cmd;
				nfill_q <= '0;
				scan_q  <= '0;
				found_q <= 1'b0; ofree_q <= 1'b0; cfound_q <= 1'b0;
			end
			ST_SCAN: begin
				if (cand && better) begin
					found_q  <= 1'b1;
					best_q   <= scan_q;
					bprice_q <= p_i;
					bage_q   <= age_i;
				end
				if (!valid_q[scan_q] && !ofree_q) begin
					ofree_q <= 1'b1;
					free_q  <= scan_q;
				end
				if (valid_q[scan_q] && ident_q[scan_q] == cur_q.ident && !cfound_q) begin
					cfound_q <= 1'b1;
					cidx_q   <= scan_q;
				end
				if (!scan_end) scan_q <= scan_q + 1'b1;
			end
			ST_FILL: begin
				sqty_q[best_q] <= sqty_q[best_q] - traded;
				cur_q.qty <= cur_q.qty - traded;
				nfill_q   <= nfill_q + 1'b1;
				okind_q   <= KIND_FILL;
				omaker_q  <= ident_q[best_q];
				oqty_q    <= traded;
				oprice_q  <= price_q[best_q];
				orem_q    <= cur_q.qty - traded;
				olast_q   <= 1'b0;
			end
			ST_FINAL: begin
				omaker_q <= '0; oqty_q <= '0; oprice_q <= '0; olast_q <= 1'b1;
				if (cur_q.is_cancel) begin
					okind_q <= cfound_q ? KIND_CXL_DONE : KIND_CXL_MISSING;
					orem_q  <= '0;
				end else if (cur_q.qty == '0) begin
					okind_q <= KIND_FILLED;
					orem_q  <= '0;
				end else begin
					okind_q <= ofree_q ? KIND_RESTED : KIND_DROPPED;
					orem_q  <= cur_q.qty;
					if (ofree_q) begin
						sell_q[free_q]  <= cur_q.is_sell;
						price_q[free_q] <= cur_q.price;
						sqty_q[free_q]  <= cur_q.qty;
						ident_q[free_q] <= cur_q.ident;
						arr_q[free_q]   <= arrival_q;
					end
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					scan_q  <= '0;
					found_q <= 1'b0; ofree_q <= 1'b0; cfound_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	`LOM_ASSERT_IMP(a_fill_valid, clk, arst_n, state_q == ST_FILL, valid_q[best_q] && found_q)
	`LOM_ASSERT_NXT(a_fill_to_out, clk, arst_n, state_q == ST_FILL, state_q == ST_OUT && !olast_q)
	`LOM_ASSERT_IMP(a_fill_cap, clk, arst_n, state_q == ST_FILL, nfill_q < CntW'(ORDER_SLOTS))
	`LOM_ASSERT_NXT(a_final_last, clk, arst_n, state_q == ST_FINAL, olast_q)
endmodule

@@ design/limit_order_matcher.sv @@
// Top level of the limit order matcher: front queue plus matching back end.
// Usage:
//  s_axis carries orders/cancels; m_axis carries result transfers, tlast on
//  the final result of each input. An add yields zero or more fills then a
//  rested, fully filled or dropped result; a cancel yields one result.
//  A result needs a full scan of the slot table (one slot per cycle) to find
//  the best crossing order; a fill or final step then updates the slot and
//  registers the result. A two-entry command queue lets new inputs be taken
//  while the back end works. Reset empties the table and the queue and
//  clears the arrival stamp counter. When the receiver stalls, the result
//  holds in the output register and the back end waits; the queue keeps
//  accepting until full.
module limit_order_matcher
	import lom_pkg::*;
#(
	parameter int ORDER_SLOTS = DefOrderSlots
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// opcode, order_side, order_ident, order_price, order_qty, 6 zero bits
	input  logic [135:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result_kind, maker_ident, fill_qty, fill_price, remaining_qty, 5 zero bits
	output logic [167:0] m_axis_tdata,
	output logic         m_axis_tlast
);
	logic        cmd_valid, cmd_ready;
	cmd_t        cmd;
	logic [162:0] res;

	lom_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata[129:0]),
		.cmd_valid, .cmd_ready, .cmd
	);

	lom_back #(.ORDER_SLOTS(ORDER_SLOTS)) u_back (
		.clk, .arst_n,
		.cmd_valid, .cmd_ready, .cmd,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(res), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {5'b0, res};
endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the limit order matcher: directed table, table fill and sweep, then random order flow.
`timescale 1ns / 100ps

module testbench;
	import lom_pkg::*;

	localparam int NSLOT = DefOrderSlots;
	localparam int RAND_ITEMS = 180;
	localparam int CALM_ITEMS = 40;
	localparam int STALL_LIMIT = 20000;

	// One result transfer as the block reports it
	typedef struct {
		kind_t       kind;
		logic [63:0] maker;
		logic [31:0] fqty;
		logic [31:0] fprice;
		logic [31:0] rem;
		logic        last;
	} report_t;

	// Directed stimulus row; chk marks a typed-in final result
	typedef struct {
		opcode_t     op;
		logic        sell;
		logic [63:0] id;
		logic [31:0] price;
		logic [31:0] qty;
		logic        chk;
		kind_t       kind;
		logic [31:0] rem;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// opcode, order_side, order_ident, order_price, order_qty, 6 zero bits
	logic [135:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// result_kind, maker_ident, fill_qty, fill_price, remaining_qty, 5 zero bits
	logic [167:0] m_axis_tdata;
	logic         m_axis_tlast;

	limit_order_matcher dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// Book mirror
	logic        bk_valid [NSLOT];
	logic        bk_sell [NSLOT];
	logic [31:0] bk_price [NSLOT];
	logic [31:0] bk_qty [NSLOT];
	logic [63:0] bk_id [NSLOT];
	logic [31:0] bk_stamp [NSLOT];
	logic [31:0] stamp_ctr;

	report_t     pending_reports[$];
	logic [63:0] known_ids[$];
	int          errors = 0;
	int          idle_cycles = 0;
	bit          calm = 1'b0;
	int          n_fills = 0;
	int          n_dropped = 0;
	int          n_cancels = 0;
	int          n_inputs = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic report_t mk(kind_t k, logic [63:0] mkr, logic [31:0] q,
			logic [31:0] p, logic [31:0] r, logic l);
		report_t t;
		t.kind = k; t.maker = mkr; t.fqty = q; t.fprice = p; t.rem = r; t.last = l;
		return t;
	endfunction

	// Best crossing resting order on the opposite side, or -1
	function automatic int best_slot(logic sell, logic [31:0] lim);
		int b;
		logic better;
		b = -1;
		for (int i = 0; i < NSLOT; i++) begin
			if (!bk_valid[i] || bk_sell[i] == sell) continue;
			if (sell && (bk_price[i] == 0 || bk_price[i] < lim)) continue;
			if (!sell && bk_price[i] > lim) continue;
			if (b < 0) begin
				b = i;
				continue;
			end
			if (bk_price[i] != bk_price[b])
				better = sell ? (bk_price[i] > bk_price[b]) : (bk_price[i] < bk_price[b]);
			else
				better = (stamp_ctr - bk_stamp[i]) > (stamp_ctr - bk_stamp[b]);
			if (better) b = i;
		end
		return b;
	endfunction

	// Apply one accepted input to the book and queue its reports
	task automatic match_order(opcode_t op, logic sell, logic [63:0] id,
			logic [31:0] price, logic [31:0] qty, ref report_t out[$]);
		int m, n;
		logic [31:0] t;
		out = {};
		n = 0;
		if (op == OP_CANCEL) begin
			n_cancels++;
			for (int i = 0; i < NSLOT; i++) begin
				if (bk_valid[i] && bk_id[i] == id) begin
					bk_valid[i] = 1'b0;
					out = {out, mk(KIND_CXL_DONE, '0, '0, '0, '0, 1'b1)};
					return;
				end
			end
			out = {out, mk(KIND_CXL_MISSING, '0, '0, '0, '0, 1'b1)};
			return;
		end
		while (qty != 0 && n < NSLOT) begin
			m = best_slot(sell, price);
			if (m < 0) break;
			t = (qty < bk_qty[m]) ? qty : bk_qty[m];
			qty -= t;
			bk_qty[m] -= t;
			out = {out, mk(KIND_FILL, bk_id[m], t, bk_price[m], qty, 1'b0)};
			n_fills++;
			n++;
			if (bk_qty[m] == 0) bk_valid[m] = 1'b0;
		end
		if (qty == 0) begin
			out = {out, mk(KIND_FILLED, '0, '0, '0, '0, 1'b1)};
			return;
		end
		for (int i = 0; i < NSLOT; i++) begin
			if (!bk_valid[i]) begin
				bk_valid[i] = 1'b1; bk_sell[i] = sell; bk_price[i] = price;
				bk_qty[i] = qty; bk_id[i] = id; bk_stamp[i] = stamp_ctr;
				stamp_ctr++;
				out = {out, mk(KIND_RESTED, '0, '0, '0, qty, 1'b1)};
				return;
			end
		end
		n_dropped++;
		out = {out, mk(KIND_DROPPED, '0, '0, '0, qty, 1'b1)};
	endtask

	// Drive one input, wait for its transfer, then queue what it should produce
	task automatic send(row_t r, int gap);
		report_t got[$];
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, r.qty, r.price, r.id, r.sell, r.op};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		n_inputs++;
		match_order(r.op, r.sell, r.id, r.price, r.qty, got);
		if (r.chk) got[got.size()-1] = mk(r.kind, '0, '0, '0, r.rem, 1'b1);
		foreach (got[i]) pending_reports = {pending_reports, got[i]};
		if (r.op == OP_ADD) known_ids = {known_ids, r.id};
	endtask

	function automatic row_t mkrow(opcode_t op, logic sell, logic [63:0] id,
			logic [31:0] price, logic [31:0] qty);
		row_t r;
		r.op = op; r.sell = sell; r.id = id; r.price = price; r.qty = qty;
		r.chk = 1'b0; r.kind = KIND_FILL; r.rem = '0;
		return r;
	endfunction

	function automatic row_t typed(row_t r, kind_t k, logic [31:0] rem);
		r.chk = 1'b1; r.kind = k; r.rem = rem;
		return r;
	endfunction

	function automatic int pick_gap();
		if (calm || $urandom_range(0, 3) != 0) return 0;
		return $urandom_range(1, 10);
	endfunction

	// Result side: ready comes in random bursts, steady once calm
	initial begin
		forever begin
			if (calm) begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(0, 2) != 0);
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	// Compare each result transfer ahead of the edge that takes it
	always @(negedge clk) begin
		report_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_reports.size() == 0) begin
				$error("result with no expectation: kind %0d", m_axis_tdata[2:0]);
				errors++;
			end else begin
				e = pending_reports.pop_front();
				if (m_axis_tdata[2:0] !== e.kind) begin
					$error("result_kind exp %0d got %0d", e.kind, m_axis_tdata[2:0]);
					errors++;
				end
				if (m_axis_tdata[66:3] !== e.maker) begin
					$error("maker_ident exp %0h got %0h", e.maker, m_axis_tdata[66:3]);
					errors++;
				end
				if (m_axis_tdata[98:67] !== e.fqty) begin
					$error("fill_qty exp %0d got %0d", e.fqty, m_axis_tdata[98:67]);
					errors++;
				end
				if (m_axis_tdata[130:99] !== e.fprice) begin
					$error("fill_price exp %0d got %0d", e.fprice, m_axis_tdata[130:99]);
					errors++;
				end
				if (m_axis_tdata[162:131] !== e.rem) begin
					$error("remaining_qty exp %0d got %0d", e.rem, m_axis_tdata[162:131]);
					errors++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("last exp %0d got %0d", e.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(negedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		row_t dir[$];
		row_t r;
		logic [63:0] id;
		int pick;

		for (int i = 0; i < NSLOT; i++) begin
			bk_valid[i] = 1'b0; bk_sell[i] = 1'b0; bk_price[i] = '0;
			bk_qty[i] = '0; bk_id[i] = '0; bk_stamp[i] = '0;
		end
		stamp_ctr = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: empty book, zero price and quantity, extremes, time priority
		dir = {dir, typed(mkrow(OP_CANCEL, 1'b0, 64'h5, 0, 0), KIND_CXL_MISSING, 0)};
		dir = {dir, typed(mkrow(OP_ADD, 1'b0, 64'h1, 100, 0), KIND_FILLED, 0)};
		dir = {dir, typed(mkrow(OP_ADD, 1'b0, 64'h10, 0, 7), KIND_RESTED, 7)};
		// a bid at zero never trades, so this sell at zero rests
		dir = {dir, typed(mkrow(OP_ADD, 1'b1, 64'h11, 0, 3), KIND_RESTED, 3)};
		dir = {dir, mkrow(OP_ADD, 1'b0, 64'h12, 100, 5)};
		dir = {dir, typed(mkrow(OP_ADD, 1'b1, '1, '1, '1), KIND_RESTED, '1)};
		dir = {dir, mkrow(OP_ADD, 1'b0, 64'h13, '1, 10)};
		dir = {dir, mkrow(OP_ADD, 1'b1, 64'h14, 100, 1)};
		dir = {dir, mkrow(OP_ADD, 1'b0, 64'h20, 500, 4)};
		dir = {dir, mkrow(OP_ADD, 1'b0, 64'h21, 500, 4)};
		dir = {dir, mkrow(OP_ADD, 1'b0, 64'h22, 600, 2)};
		dir = {dir, mkrow(OP_ADD, 1'b1, 64'h23, 400, 9)};
		dir = {dir, mkrow(OP_CANCEL, 1'b0, 64'h21, 0, 0)};
		dir = {dir, typed(mkrow(OP_CANCEL, 1'b1, 64'h21, 0, 0), KIND_CXL_MISSING, 0)};
		dir = {dir, typed(mkrow(OP_CANCEL, 1'b0, 64'h10, 0, 0), KIND_CXL_DONE, 0)};
		dir = {dir, typed(mkrow(OP_CANCEL, 1'b0, '1, 0, 0), KIND_CXL_DONE, 0)};
		dir = {dir, typed(mkrow(OP_ADD, 1'b1, 64'h30, 0, 0), KIND_FILLED, 0)};
		foreach (dir[i]) send(dir[i], pick_gap());

		// Fill the table with bids, overflow it, then sweep with one big sell
		for (int i = 0; i < NSLOT + 2; i++)
			send(mkrow(OP_ADD, 1'b0, 64'h1000 + i, 1 + (i % 3), 1 + (i % 4)), pick_gap());
		send(mkrow(OP_ADD, 1'b1, 64'h2000, 1, 200), pick_gap());

		// Random order flow around a narrow price band
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 2) begin
				s_axis_tvalid <= 1'b0;
				wait (pending_reports.size() == 0);
				@(posedge clk);
			end
			if (n == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
			pick = $urandom_range(0, 99);
			id = {$urandom, $urandom};
			if (pick < 62) begin
				r = mkrow(OP_ADD, 1'($urandom_range(0, 1)), id, $urandom_range(980, 1020),
					$urandom_range(1, 20));
			end else if (pick < 68) begin
				r = mkrow(OP_ADD, 1'($urandom_range(0, 1)), id, $urandom, $urandom);
			end else if (pick < 72) begin
				r = mkrow(OP_ADD, 1'($urandom_range(0, 1)), id, $urandom_range(0, 2),
					$urandom_range(0, 3));
			end else begin
				if ($urandom_range(0, 9) < 7 && known_ids.size() > 0)
					id = known_ids[$urandom_range(0, known_ids.size() - 1)];
				r = mkrow(OP_CANCEL, 1'($urandom_range(0, 1)), id, $urandom, $urandom);
			end
			send(r, pick_gap());
		end
		s_axis_tvalid <= 1'b0;

		wait (pending_reports.size() == 0);
		repeat (100) @(posedge clk);
		if (pending_reports.size() != 0) begin
			$error("%0d expected results never arrived", pending_reports.size());
			errors++;
		end
		$display("Covered %0d inputs: %0d fills, %0d cancels, %0d dropped on a full book.",
			n_inputs, n_fills, n_cancels, n_dropped);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
